FILE: sv/ilda_pkg.sv
// Shared types, constants and codes for the point record to scanner packet decoder.
package ilda_pkg;

    // Coordinate scale: the divisor is a power of two, given by its shift.
    localparam int COORD_SHIFT     = 4;
    localparam int COORD_SCALE_DIV = 1 << COORD_SHIFT;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_ADDR_W      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int RGB_W           = 24;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 56;

    localparam int BLANK_BIT = 14;

    localparam logic [11:0] NEG_OFFSET = 12'd2048;
    localparam logic [11:0] POS_OFFSET = 12'd2047;

    // Record layouts.
    localparam logic [2:0] FMT_2D    = 3'd1;
    localparam logic [2:0] FMT_EXT3D = 3'd4;
    localparam logic [2:0] FMT_TRUE  = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_POINT_FORMAT = 2'd0;
    localparam logic [1:0] REG_USE_FILE_PAL = 2'd1;
    localparam logic [1:0] REG_RATE_BYTE    = 2'd2;

    typedef enum logic [1:0] {
        REQ_POINT    = 2'd0,
        REQ_FILE_PAL = 2'd1,
        REQ_DEF_PAL  = 2'd2
    } t_req;

endpackage

FILE: sv/ilda_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ilda_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ilda_point_to_scanner_packet.sv
// Top level of the point record to scanner packet decoder.
//
// Input stream (s_axis): one transaction carries either a point record or a
// palette write, selected by tuser. Point records yield one packet on the
// output stream (m_axis); palette writes and unknown request codes yield none.
// Palette writes take effect for any point accepted in a later cycle.
// Throughput is one transaction per cycle while the receiver does not stall. A
// point passes through stage one, which holds the palette RAM read and the
// coordinate scaling, and then through the colour selection into the output
// register on its way to m_axis.
// When the receiver stalls, the output register and the stage before it hold
// their contents; s_axis_tready falls only once both are full.
// The APB port sets the record format, the palette choice and the rate byte;
// pready is always high and writes land on the access cycle.
// Reset clears the pipeline valid flags and the configuration registers.
// The two palette RAMs are not cleared: an entry must be written before a
// point reads it.
module ilda_point_to_scanner_packet (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ilda_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ilda_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ilda_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: word0_raw, word1_raw, word2_raw, word3_raw, word4_raw,
    // entry_index, entry_rgb
    input  logic [ilda_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: req_type
    input  logic [1:0]                          s_axis_tuser,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: x_code, y_code, red, green, blue, rate_out
    output logic [ilda_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int AW = ilda_pkg::PAL_ADDR_W;

    function automatic logic [15:0] swap16(input logic [15:0] w);
        return {w[7:0], w[15:8]};
    endfunction

    // Divide by the scale truncating toward zero, then add the offset.
    function automatic logic [11:0] coord_code(input logic [15:0] c);
        logic signed [16:0] biased;
        logic signed [16:0] q;
        logic               neg;
        neg    = c[15];
        biased = $signed({c[15], c}) +
                 (neg ? 17'(ilda_pkg::COORD_SCALE_DIV - 1) : 17'sd0);
        q      = biased >>> ilda_pkg::COORD_SHIFT;
        return q[11:0] + (neg ? ilda_pkg::NEG_OFFSET : ilda_pkg::POS_OFFSET);
    endfunction

    // Configuration registers
    logic [2:0] r_point_format;
    logic       r_use_file_pal;
    logic [7:0] r_rate_byte;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_format <= 3'd0;
            r_use_file_pal <= 1'b0;
            r_rate_byte    <= 8'd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                ilda_pkg::REG_POINT_FORMAT: r_point_format <= pwdata[2:0];
                ilda_pkg::REG_USE_FILE_PAL: r_use_file_pal <= pwdata[0];
                ilda_pkg::REG_RATE_BYTE:    r_rate_byte    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ilda_pkg::REG_POINT_FORMAT: prdata = {29'd0, r_point_format};
            ilda_pkg::REG_USE_FILE_PAL: prdata = {31'd0, r_use_file_pal};
            ilda_pkg::REG_RATE_BYTE:    prdata = {24'd0, r_rate_byte};
            default:                    prdata = '0;
        endcase
    end

    // Input unpacking
    logic [15:0] in_w0, in_w1, in_w2, in_w3, in_w4;
    logic [7:0]  in_idx;
    logic [23:0] in_rgb;
    logic [15:0] in_st;
    logic        in_acc, in_point, in_fwr, in_dwr, in_idx_ok;

    assign in_w0  = swap16(s_axis_tdata[15:0]);
    assign in_w1  = swap16(s_axis_tdata[31:16]);
    assign in_w2  = swap16(s_axis_tdata[47:32]);
    assign in_w3  = swap16(s_axis_tdata[63:48]);
    assign in_w4  = swap16(s_axis_tdata[79:64]);
    assign in_idx = s_axis_tdata[87:80];
    assign in_rgb = s_axis_tdata[111:88];
    assign in_st  = (r_point_format == ilda_pkg::FMT_2D) ? in_w2 : in_w3;

    assign in_idx_ok = {1'b0, in_idx} < 9'(ilda_pkg::PALETTE_ENTRIES);

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_point = in_acc && (s_axis_tuser == ilda_pkg::REQ_POINT);
    assign in_fwr   = in_acc && (s_axis_tuser == ilda_pkg::REQ_FILE_PAL) && in_idx_ok;
    assign in_dwr   = in_acc && (s_axis_tuser == ilda_pkg::REQ_DEF_PAL) && in_idx_ok;

    // Palette RAMs, read at the status low byte when a point is accepted
    logic [AW-1:0]              pal_raddr;
    logic [ilda_pkg::RGB_W-1:0] fpal_rdata, dpal_rdata;

    assign pal_raddr = in_st[AW-1:0];

    ilda_ram #(
        .WIDTH (ilda_pkg::RGB_W),
        .DEPTH (ilda_pkg::PALETTE_ENTRIES)
    ) u_file_pal (
        .i_clk   (i_clk),
        .i_we    (in_fwr),
        .i_waddr (in_idx[AW-1:0]),
        .i_wdata (in_rgb),
        .i_re    (in_point),
        .i_raddr (pal_raddr),
        .o_rdata (fpal_rdata)
    );

    ilda_ram #(
        .WIDTH (ilda_pkg::RGB_W),
        .DEPTH (ilda_pkg::PALETTE_ENTRIES)
    ) u_def_pal (
        .i_clk   (i_clk),
        .i_we    (in_dwr),
        .i_waddr (in_idx[AW-1:0]),
        .i_wdata (in_rgb),
        .i_re    (in_point),
        .i_raddr (pal_raddr),
        .o_rdata (dpal_rdata)
    );

    // Stage one: scaled coordinates and the record words needed for colour
    logic        r_s1_valid;
    logic [11:0] r_s1_x_code, r_s1_y_code;
    logic [15:0] r_s1_st, r_s1_z, r_s1_st2;
    logic        r_s1_pal_ok;
    logic        s1_adv;

    // Output register
    logic                             r_m_valid;
    logic [ilda_pkg::OUT_TDATA_W-1:0] r_m_data;

    assign s1_adv        = !r_m_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= in_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_point) begin
            r_s1_x_code <= coord_code(in_w0);
            r_s1_y_code <= ~coord_code(in_w1);
            r_s1_st     <= in_st;
            r_s1_z      <= in_w2;
            r_s1_st2    <= in_w4;
            r_s1_pal_ok <= {8'd0, in_st[7:0]} < 16'(ilda_pkg::PALETTE_ENTRIES);
        end
    end

    // Stage two: colour selection
    logic [23:0] col;

    always_comb begin
        if (r_s1_st[ilda_pkg::BLANK_BIT] && (r_point_format != ilda_pkg::FMT_TRUE)) begin
            col = 24'd0;
        end else if (r_use_file_pal) begin
            col = r_s1_pal_ok ? fpal_rdata : 24'd0;
        end else if (r_point_format == ilda_pkg::FMT_TRUE) begin
            col = r_s1_z[ilda_pkg::BLANK_BIT] ? 24'd0
                : {r_s1_st[7:0], r_s1_st[15:8], r_s1_z[7:0]};
        end else if (r_point_format == ilda_pkg::FMT_EXT3D) begin
            col = {r_s1_st2[7:0], r_s1_st2[15:8], r_s1_st[7:0]};
        end else begin
            col = r_s1_pal_ok ? dpal_rdata : 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_adv) begin
            r_m_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_m_data <= {r_rate_byte, col[7:0], col[15:8], col[23:16],
                         r_s1_y_code, r_s1_x_code};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // A palette write or an unknown request never leaves an item in stage one.
    a_write_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (s_axis_tuser != ilda_pkg::REQ_POINT)) |=> !r_s1_valid)
        else $error("palette write left an item in stage one");

    // An accepted point is in stage one on the next cycle.
    a_point_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_point |=> r_s1_valid)
        else $error("accepted point lost before stage one");

    // A blocked stage one keeps its item and its codes.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_x_code)
                                     && $stable(r_s1_y_code)))
        else $error("stage one changed while blocked");

    // The input side only backs off when both stages are full.
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_m_valid && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/ilda_point_to_scanner_packet_test.sv
// Self-checking testbench for the point record to scanner packet decoder.
`timescale 1ns / 1ps

module ilda_point_to_scanner_packet_test;

    localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;
    localparam int unsigned IDLE_LIMIT    = 3000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_ITEMS   = 110;

    // Result layout on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [7:0]  rate_out;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] y_code;
        logic [11:0] x_code;
    } t_scanner_packet;

    // Keeps its own copy of both palettes and the registers, and the packets still owed.
    class t_packet_board;
        logic [ilda_pkg::RGB_W-1:0] file_pal [ilda_pkg::PALETTE_ENTRIES];
        logic [ilda_pkg::RGB_W-1:0] dflt_pal [ilda_pkg::PALETTE_ENTRIES];
        bit                         file_set [ilda_pkg::PALETTE_ENTRIES];
        bit                         dflt_set [ilda_pkg::PALETTE_ENTRIES];
        logic [7:0]                 file_list [$];
        logic [7:0]                 dflt_list [$];
        logic [2:0]                 fmt;
        bit                         use_file;
        logic [7:0]                 rate;
        t_scanner_packet            packets_due [$];
        int unsigned                mismatches;

        function new();
            fmt = '0;
            use_file = 1'b0;
            rate = '0;
            mismatches = 0;
        endfunction

        static function logic [15:0] swap_bytes(logic [15:0] w);
            return {w[7:0], w[15:8]};
        endfunction

        static function logic [11:0] deflection_code(logic [15:0] value);
            int c;
            int q;
            c = int'($signed(value));
            q = c / ilda_pkg::COORD_SCALE_DIV;
            return (c < 0) ? 12'(q + int'(ilda_pkg::NEG_OFFSET))
                           : 12'(q + int'(ilda_pkg::POS_OFFSET));
        endfunction

        function int unsigned pending();
            return packets_due.size();
        endfunction

        function void apply_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                ilda_pkg::REG_POINT_FORMAT: fmt = value[2:0];
                ilda_pkg::REG_USE_FILE_PAL: use_file = value[0];
                ilda_pkg::REG_RATE_BYTE:    rate = value[7:0];
                default: ;
            endcase
        endfunction

        // Steers the status index of a point onto a written entry whenever the
        // colour for that point would come from a palette.
        function void avoid_unwritten(inout logic [15:0] w2, inout logic [15:0] w3);
            logic [15:0] status;
            logic [7:0]  idx;
            status = (fmt == ilda_pkg::FMT_2D) ? swap_bytes(w2) : swap_bytes(w3);
            idx = status[7:0];
            if (status[ilda_pkg::BLANK_BIT] && fmt != ilda_pkg::FMT_TRUE)
                return;
            if (use_file) begin
                if (!file_set[idx])
                    idx = file_list[$urandom_range(0, file_list.size() - 1)];
            end else if (fmt == ilda_pkg::FMT_TRUE || fmt == ilda_pkg::FMT_EXT3D) begin
                return;
            end else if (!dflt_set[idx]) begin
                idx = dflt_list[$urandom_range(0, dflt_list.size() - 1)];
            end
            // The status low byte travels in the high byte of the raw word.
            if (fmt == ilda_pkg::FMT_2D)
                w2[15:8] = idx;
            else
                w3[15:8] = idx;
        endfunction

        function void accept_item(logic [1:0] req, logic [ilda_pkg::IN_TDATA_W-1:0] d);
            logic [7:0]                 idx;
            logic [ilda_pkg::RGB_W-1:0] rgb;
            logic [ilda_pkg::RGB_W-1:0] col;
            logic [15:0]                wx;
            logic [15:0]                wy;
            logic [15:0]                wz;
            logic [15:0]                st;
            logic [15:0]                st2;
            t_scanner_packet            p;
            idx = d[87:80];
            rgb = d[111:88];
            case (req)
                ilda_pkg::REQ_FILE_PAL: begin
                    if (idx < ilda_pkg::PALETTE_ENTRIES) begin
                        file_pal[idx] = rgb;
                        if (!file_set[idx]) begin
                            file_set[idx] = 1'b1;
                            file_list.push_back(idx);
                        end
                    end
                end
                ilda_pkg::REQ_DEF_PAL: begin
                    if (idx < ilda_pkg::PALETTE_ENTRIES) begin
                        dflt_pal[idx] = rgb;
                        if (!dflt_set[idx]) begin
                            dflt_set[idx] = 1'b1;
                            dflt_list.push_back(idx);
                        end
                    end
                end
                ilda_pkg::REQ_POINT: begin
                    wx  = swap_bytes(d[15:0]);
                    wy  = swap_bytes(d[31:16]);
                    wz  = swap_bytes(d[47:32]);
                    st  = (fmt == ilda_pkg::FMT_2D) ? wz : swap_bytes(d[63:48]);
                    st2 = swap_bytes(d[79:64]);
                    if (st[ilda_pkg::BLANK_BIT] && fmt != ilda_pkg::FMT_TRUE)
                        col = '0;
                    else if (use_file)
                        col = (st[7:0] < ilda_pkg::PALETTE_ENTRIES) ? file_pal[st[7:0]] : '0;
                    else if (fmt == ilda_pkg::FMT_TRUE)
                        col = wz[ilda_pkg::BLANK_BIT] ? '0 : {st[7:0], st[15:8], wz[7:0]};
                    else if (fmt == ilda_pkg::FMT_EXT3D)
                        col = {st2[7:0], st2[15:8], st[7:0]};
                    else
                        col = (st[7:0] < ilda_pkg::PALETTE_ENTRIES) ? dflt_pal[st[7:0]] : '0;
                    p.x_code   = deflection_code(wx);
                    p.y_code   = 12'hFFF - deflection_code(wy);
                    p.red      = col[23:16];
                    p.green    = col[15:8];
                    p.blue     = col[7:0];
                    p.rate_out = rate;
                    packets_due.push_back(p);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_packet(logic [ilda_pkg::OUT_TDATA_W-1:0] data);
            t_scanner_packet got;
            t_scanner_packet want;
            got = t_scanner_packet'(data);
            if (packets_due.size() == 0) begin
                $error("packet with no point record outstanding: tdata %h", data);
                mismatches++;
                return;
            end
            want = packets_due.pop_front();
            compare_field("x_code", want.x_code, got.x_code);
            compare_field("y_code", want.y_code, got.y_code);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("rate_out", want.rate_out, got.rate_out);
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [ilda_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [ilda_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [ilda_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // word0_raw, word1_raw, word2_raw, word3_raw, word4_raw, entry_index, entry_rgb
    logic [ilda_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // req_type
    logic [1:0]                       s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // x_code, y_code, red, green, blue, rate_out
    logic [ilda_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int unsigned sink_hold = 0;
    bit          sink_calm = 1'b0;

    t_packet_board sb = new();

    wire in_fire  = s_axis_tvalid && s_axis_tready;
    wire out_fire = m_axis_tvalid && m_axis_tready;

    ilda_point_to_scanner_packet dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial forever #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] corner_value();
        logic [15:0] corners [10];
        corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h000F,
                    16'hFFF1, 16'h0010, 16'hFFF0, 16'h0001, 16'hFFEF};
        return corners[$urandom_range(0, 9)];
    endfunction

    function automatic logic [ilda_pkg::IN_TDATA_W-1:0] pack_item(
        logic [15:0] w0, logic [15:0] w1, logic [15:0] w2, logic [15:0] w3,
        logic [15:0] w4, logic [7:0] idx, logic [ilda_pkg::RGB_W-1:0] rgb);
        return {rgb, idx, w4, w3, w2, w1, w0};
    endfunction

    // Receiver side: random back-pressure, switched off in calm phases.
    always @(posedge i_clk) begin
        int unsigned n;
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            n = sink_calm ? 0 : idle_cycles();
            if (n == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                sink_hold <= n - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire)
                sb.check_packet(m_axis_tdata);
            if (in_fire)
                sb.accept_item(s_axis_tuser, s_axis_tdata);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (in_fire || out_fire || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("ilda_point_to_scanner_packet verification failed");
        $finish;
    end

    task automatic send_item(input logic [1:0] req,
                             input logic [ilda_pkg::IN_TDATA_W-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_sender(input int unsigned n);
        logic [127:0] noise;
        if (n != 0) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= 2'($urandom);
            s_axis_tdata  <= noise[ilda_pkg::IN_TDATA_W-1:0];
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every outstanding packet has arrived.
    task automatic settle(input int unsigned extra);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.apply_register(reg_idx, value);
        @(posedge i_clk);
    endtask

    task automatic random_item(output logic [1:0] req,
                               output logic [ilda_pkg::IN_TDATA_W-1:0] d);
        logic [15:0] w [5];
        int unsigned roll;
        roll = $urandom_range(0, 99);
        for (int k = 0; k < 5; k++)
            w[k] = 16'($urandom);
        if (roll < 3) begin
            req = REQ_UNKNOWN;
        end else if (roll < 10) begin
            req = ilda_pkg::REQ_FILE_PAL;
        end else if (roll < 17) begin
            req = ilda_pkg::REQ_DEF_PAL;
        end else begin
            req = ilda_pkg::REQ_POINT;
            if ($urandom_range(0, 4) == 0)
                w[0] = t_packet_board::swap_bytes(corner_value());
            if ($urandom_range(0, 4) == 0)
                w[1] = t_packet_board::swap_bytes(corner_value());
            sb.avoid_unwritten(w[2], w[3]);
        end
        d = pack_item(w[0], w[1], w[2], w[3], w[4], 8'($urandom), 24'($urandom));
    endtask

    // Extremes of the palettes and coordinates, blanking, and an unknown request.
    task automatic directed_items();
        logic [15:0] xs [8];
        logic [15:0] st;
        xs = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h000F, 16'hFFF1, 16'h0010, 16'hFFEF};
        send_item(ilda_pkg::REQ_FILE_PAL, pack_item('0, '0, '0, '0, '0, 8'h00, 24'hFFFFFF));
        send_item(ilda_pkg::REQ_FILE_PAL, pack_item('1, '1, '1, '1, '1, 8'hFF, 24'h000000));
        idle_sender(idle_cycles());
        send_item(ilda_pkg::REQ_DEF_PAL, pack_item('0, '0, '0, '0, '0, 8'h00, 24'h000000));
        send_item(ilda_pkg::REQ_DEF_PAL, pack_item('1, '1, '1, '1, '1, 8'hFF, 24'hFFFFFF));
        send_item(REQ_UNKNOWN, '1);
        for (int k = 0; k < 8; k++) begin
            st = 16'($urandom);
            st[ilda_pkg::BLANK_BIT] = (k % 3 == 2);
            st[7:0] = k[0] ? 8'hFF : 8'h00;
            send_item(ilda_pkg::REQ_POINT, pack_item(
                t_packet_board::swap_bytes(xs[k]),
                t_packet_board::swap_bytes(xs[7 - k]),
                16'($urandom), t_packet_board::swap_bytes(st), 16'($urandom),
                8'($urandom), 24'($urandom)));
            idle_sender(idle_cycles());
        end
    endtask

    task automatic run_phase(input logic [2:0] fmt, input bit file_pal, input logic [7:0] rate,
                             input bit calm, input bit hold_mid);
        logic [1:0]                      req;
        logic [ilda_pkg::IN_TDATA_W-1:0] d;
        settle(SETTLE_CYCLES);
        write_register(ilda_pkg::REG_POINT_FORMAT, 32'(fmt));
        write_register(ilda_pkg::REG_USE_FILE_PAL, 32'(file_pal));
        write_register(ilda_pkg::REG_RATE_BYTE, 32'(rate));
        sink_calm <= calm;
        for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
            if (hold_mid && i == PHASE_ITEMS / 2)
                settle(0);
            random_item(req, d);
            send_item(req, d);
            if (!calm)
                idle_sender(idle_cycles());
        end
    endtask

    initial begin : stimulus
        logic [7:0] rate;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_items();
        // Every layout with and without the file palette; rate extremes at the ends.
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0)
                rate = 8'h00;
            else if (ph == 1 || ph == 11)
                rate = 8'hFF;
            else
                rate = 8'($urandom);
            run_phase(3'(ph / 2), ph[0], rate, ph % 4 == 3, ph % 3 == 1);
        end
        settle(SETTLE_CYCLES);
        if (sb.mismatches == 0)
            $display("ilda_point_to_scanner_packet verification clean");
        else
            $display("ilda_point_to_scanner_packet verification failed");
        $finish;
    end

endmodule
